/* hw/rtl/nearest_prototype_ema_predictor_top_macros.svh */
// ----------------------------------------------------------------------------
// nearest prototype ema predictor assertion macros
// concurrent check helpers for the rtl top, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef NEAREST_PROTOTYPE_EMA_PREDICTOR_TOP_MACROS_SVH
`define NEAREST_PROTOTYPE_EMA_PREDICTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define NPEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NPEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NPEP_ASSERT_NOW(lbl, ante, cons, msg)
`define NPEP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/npep_pkg.sv */
// ----------------------------------------------------------------------------
// npep_pkg
// shared types and constants of the nearest prototype ema predictor
// ----------------------------------------------------------------------------
package npep_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int VAL_W    = 15;
  localparam int IDX_W    = 3;

  // number of level registers
  localparam int LEVEL_SLOTS = 8;

  // largest q1.14 magnitude
  localparam logic [VAL_W-1:0] MAG_MAX = 15'h7fff;

  // ema weights, they sum to 65536
  localparam logic [16:0] KEEP_WEIGHT = 17'd64225;
  localparam logic [10:0] NEW_WEIGHT  = 11'd1311;

  // level reset values
  localparam logic [VAL_W-1:0] LEVEL_RESET [LEVEL_SLOTS] = '{
    15'd0, 15'd4915, 15'd9830, 15'd13107, 15'd0, 15'd0, 15'd0, 15'd0
  };

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SEARCH,
    ST_MULT,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             acc_step;
    logic             search_first;
    logic             search_step;
    logic [IDX_W-1:0] model_idx;
    logic             mult;
    logic             update;
    logic             emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } status_t;

endpackage

/* hw/rtl/npep_ctrl.sv */
// ----------------------------------------------------------------------------
// npep_ctrl
// sequencer: accept, accumulate window, search models, ema update, emit
// ----------------------------------------------------------------------------
module npep_ctrl #(
  parameter int WINDOW_LENGTH = 16,
  parameter int MODEL_COUNT   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  npep_pkg::status_t status,
  output npep_pkg::cmd_t    cmd
);

  localparam int ACC_W = $clog2(WINDOW_LENGTH);
  localparam logic [ACC_W-1:0] LAST_ACC = ACC_W'(WINDOW_LENGTH - 1);
  localparam logic [npep_pkg::IDX_W-1:0] LAST_MODEL = npep_pkg::IDX_W'(MODEL_COUNT - 1);

  npep_pkg::state_t              state;
  npep_pkg::state_t              state_next;
  logic [ACC_W-1:0]              acc_cnt;
  logic [npep_pkg::IDX_W-1:0]    model_cnt;
  logic                          search_first;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= npep_pkg::ST_IDLE;
      acc_cnt      <= '0;
      model_cnt    <= '0;
      search_first <= 1'b0;
    end else begin
      state        <= state_next;
      search_first <= (state == npep_pkg::ST_ACCUM);
      if (cmd.load) begin
        acc_cnt <= '0;
      end else if (cmd.acc_step) begin
        acc_cnt <= acc_cnt + 1'b1;
      end
      if (state == npep_pkg::ST_ACCUM) begin
        model_cnt <= '0;
      end else if (cmd.search_step && model_cnt != LAST_MODEL) begin
        model_cnt <= model_cnt + 1'b1;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    cmd          = '0;
    case (state)
      npep_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = npep_pkg::ST_ACCUM;
        end
      end
      npep_pkg::ST_ACCUM: begin
        cmd.acc_step = 1'b1;
        if (acc_cnt == LAST_ACC) begin
          state_next = npep_pkg::ST_SEARCH;
        end
      end
      npep_pkg::ST_SEARCH: begin
        cmd.search_step  = 1'b1;
        cmd.search_first = search_first;
        cmd.model_idx    = model_cnt;
        if (model_cnt == LAST_MODEL && !search_first && !status.div_busy) begin
          state_next = npep_pkg::ST_MULT;
        end
      end
      npep_pkg::ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = npep_pkg::ST_UPDATE;
      end
      npep_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = npep_pkg::ST_EMIT;
      end
      npep_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = npep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = npep_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/npep_dp.sv */
// ----------------------------------------------------------------------------
// npep_dp
// window, level registers, distance lanes, mean, ema update and output word
// ----------------------------------------------------------------------------
module npep_dp #(
  parameter int WINDOW_LENGTH = 16,
  parameter int MODEL_COUNT   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  npep_pkg::cmd_t                        cmd,
  output npep_pkg::status_t                     status,
  input  logic signed [npep_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  cfg_write,
  input  logic [npep_pkg::IDX_W-1:0]            cfg_index,
  input  logic [npep_pkg::VAL_W-1:0]            cfg_data,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [npep_pkg::SAMPLE_W-1:0]  drive,
  output logic [npep_pkg::IDX_W-1:0]            chosen_model
);

  localparam int VW    = npep_pkg::VAL_W;
  localparam int SH    = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = VW + SH;

  logic [VW-1:0]                 level     [npep_pkg::LEVEL_SLOTS];
  logic [VW-1:0]                 avg_mem   [npep_pkg::LEVEL_SLOTS];
  logic [VW-1:0]                 window    [WINDOW_LENGTH];
  logic [SUM_W-1:0]              dist_q    [npep_pkg::LEVEL_SLOTS];
  logic [SUM_W-1:0]              sum_q;
  logic [SUM_W-1:0]              best_dist_q;
  logic [npep_pkg::IDX_W-1:0]    best_q;
  logic [npep_pkg::SAMPLE_W-1:0] sample_q;
  logic [16:0]                   mag_full;
  logic [VW-1:0]                 mag;
  logic [VW-1:0]                 tap;
  logic [VW-1:0]                 mean;
  logic                          div_busy;
  logic [31:0]                   prod_keep;
  logic [25:0]                   prod_new;
  logic [32:0]                   ema_total;
  logic [VW-1:0]                 avg_calc;
  logic [VW-1:0]                 avg_q;
  logic [npep_pkg::SAMPLE_W-1:0] drive_next;

  // saturated magnitude of the incoming sample
  assign mag_full = sample[npep_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, sample})
                                                 : {1'b0, sample};
  assign mag = (mag_full > {2'b00, npep_pkg::MAG_MAX}) ? npep_pkg::MAG_MAX
                                                      : mag_full[VW-1:0];

  // level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < npep_pkg::LEVEL_SLOTS; i++) begin
        level[i] <= npep_pkg::LEVEL_RESET[i];
      end
    end else if (cfg_write) begin
      level[cfg_index] <= cfg_data;
    end
  end

  // window: shift in on load, rotate once per accumulate step
  assign tap = window[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        window[i] <= '0;
      end
    end else if (cmd.load || cmd.acc_step) begin
      window[0] <= cmd.load ? mag : window[WINDOW_LENGTH-1];
      for (int i = 1; i < WINDOW_LENGTH; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  // window sum and one l1 distance lane per model
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample;
      sum_q    <= '0;
      for (int j = 0; j < npep_pkg::LEVEL_SLOTS; j++) begin
        if (j < MODEL_COUNT) begin
          dist_q[j] <= '0;
        end
      end
    end else if (cmd.acc_step) begin
      sum_q <= sum_q + SUM_W'(tap);
      for (int j = 0; j < npep_pkg::LEVEL_SLOTS; j++) begin
        if (j < MODEL_COUNT) begin
          dist_q[j] <= dist_q[j] + SUM_W'((tap >= level[j]) ? (tap - level[j])
                                                            : (level[j] - tap));
        end
      end
    end
  end

  // nearest model search, one lane per cycle, ties keep the lower index
  always_ff @(posedge clk) begin
    if (cmd.search_step) begin
      if (cmd.search_first || dist_q[cmd.model_idx] < best_dist_q) begin
        best_dist_q <= dist_q[cmd.model_idx];
        best_q      <= cmd.model_idx;
      end
    end
  end

  // window mean
  generate
    if ((WINDOW_LENGTH & (WINDOW_LENGTH - 1)) == 0) begin : g_mean_shift
      assign mean     = sum_q[SH +: VW];
      assign div_busy = 1'b0;
    end else begin : g_mean_recip
      // multiply by the rounded-up reciprocal of the window length,
      // exact over the whole range of the window sum
      localparam int RK = SUM_W + SH;
      localparam logic [SUM_W:0] RECIP =
        (SUM_W+1)'(((64'd1 << RK) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

      logic [2*SUM_W:0] recip_prod;
      logic [VW-1:0]    mean_q;

      assign recip_prod = (2*SUM_W+1)'(sum_q) * (2*SUM_W+1)'(RECIP);

      // sum is final once the search starts
      always_ff @(posedge clk) begin
        if (cmd.search_first) begin
          mean_q <= recip_prod[RK +: VW];
        end
      end

      assign mean     = mean_q;
      assign div_busy = 1'b0;
    end
  endgenerate

  // ema products
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_keep <= 32'(npep_pkg::KEEP_WEIGHT) * 32'(avg_mem[best_q]);
      prod_new  <= 26'(npep_pkg::NEW_WEIGHT) * 26'(mean);
    end
  end

  // ema sum, scale back and cap
  assign ema_total = {1'b0, prod_keep} + {7'd0, prod_new};
  assign avg_calc  = (ema_total[32:16] > {2'b00, npep_pkg::MAG_MAX}) ? npep_pkg::MAG_MAX
                                                                      : ema_total[30:16];

  // per-model averages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < npep_pkg::LEVEL_SLOTS; i++) begin
        avg_mem[i] <= '0;
      end
    end else if (cmd.update) begin
      avg_mem[best_q] <= avg_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      avg_q <= avg_calc;
    end
  end

  // drive takes the sign opposite to the sample, zero for a zero sample
  always_comb begin
    if (sample_q == '0) begin
      drive_next = '0;
    end else if (sample_q[npep_pkg::SAMPLE_W-1]) begin
      drive_next = {1'b0, avg_q};
    end else begin
      drive_next = 16'h0 - {1'b0, avg_q};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      drive        <= drive_next;
      chosen_model <= best_q;
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_busy = result_valid && result_stall;

endmodule

/* hw/rtl/nearest_prototype_ema_predictor_top.sv */
// ----------------------------------------------------------------------------
// nearest_prototype_ema_predictor_top
// nearest prototype model selection with a per-model moving average
// ----------------------------------------------------------------------------
// One word is worked at a time. The accepted sample's magnitude enters the
// window, then the window is walked once while every model lane adds its L1
// distance in parallel. The search then visits the models in turn; for a
// window length that is not a power of two the mean comes from a multiply by
// the reciprocal of the length, registered as the search starts, in parallel
// with the search. The multiply, update and output steps follow the search
// in that order. A finished word waits in the output register while the next
// sample is taken; the sample side stalls whenever a word is in progress.
module nearest_prototype_ema_predictor_top #(
  parameter int WINDOW_LENGTH = 16,
  parameter int MODEL_COUNT   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [npep_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  cfg_write,
  input  logic [npep_pkg::IDX_W-1:0]            cfg_index,
  input  logic [npep_pkg::VAL_W-1:0]            cfg_data,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [npep_pkg::SAMPLE_W-1:0]  drive,
  output logic [npep_pkg::IDX_W-1:0]            chosen_model
);

`include "nearest_prototype_ema_predictor_top_macros.svh"

  npep_pkg::cmd_t    cmd;
  npep_pkg::status_t status;

  // sequencer
  npep_ctrl #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .MODEL_COUNT   (MODEL_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath
  npep_dp #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .MODEL_COUNT   (MODEL_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive),
    .chosen_model (chosen_model)
  );

  // checks
  `NPEP_ASSERT_NEXT(a_one_word_at_a_time, sample_valid && !sample_stall, sample_stall,
                    "second sample taken while a word is in progress")
  `NPEP_ASSERT_NOW(a_emit_into_free_slot, cmd.emit, !(result_valid && result_stall),
                   "output word overwritten while stalled")
  `NPEP_ASSERT_NOW(a_model_in_range, result_valid,
                   chosen_model <= npep_pkg::IDX_W'(MODEL_COUNT - 1),
                   "chosen model beyond model count")

endmodule

/* sim/nearest_prototype_ema_predictor_top_test.sv */
// ----------------------------------------------------------------------------
// nearest_prototype_ema_predictor_top_test
// self-checking bench: directed and random error samples against a local
// predictor of window, model search and per-model average, under random
// idling on both sides and several sets of prototype levels
// ----------------------------------------------------------------------------
module nearest_prototype_ema_predictor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_TAPS   = 16;
  localparam int MODEL_LANES   = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 220;
  localparam int PHASE_SAMPLES = 230;
  localparam int PHASES        = 8;
  localparam int HOLD_PHASE    = 4;
  localparam int REPORT_CAP    = 100;
  localparam int DIRECTED_ROWS = 22;

  // one word out of the block
  typedef struct {
    logic signed [npep_pkg::SAMPLE_W-1:0] drive;
    logic [npep_pkg::IDX_W-1:0]           model;
  } correction_t;

  // one directed row, expected values only where typed is set
  typedef struct packed {
    logic signed [npep_pkg::SAMPLE_W-1:0] smp;
    logic                                 typed;
    logic signed [npep_pkg::SAMPLE_W-1:0] drv;
    logic [npep_pkg::IDX_W-1:0]           mdl;
  } vector_t;

  localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'sd0,      1'b1, 16'sd0,    3'd0},
    '{16'sh8000,   1'b1, 16'sd40,   3'd0},
    '{16'sh7fff,   1'b1, -16'sd121, 3'd0},
    '{16'sh8001,   1'b0, 16'sd0,    3'd0},
    '{16'sd1,      1'b0, 16'sd0,    3'd0},
    '{-16'sd1,     1'b0, 16'sd0,    3'd0},
    '{16'sd0,      1'b0, 16'sd0,    3'd0},
    '{16'sd16384,  1'b0, 16'sd0,    3'd0},
    '{-16'sd16384, 1'b0, 16'sd0,    3'd0},
    '{16'sd13107,  1'b0, 16'sd0,    3'd0},
    '{16'sd13107,  1'b0, 16'sd0,    3'd0},
    '{-16'sd13107, 1'b0, 16'sd0,    3'd0},
    '{16'sd13107,  1'b0, 16'sd0,    3'd0},
    '{-16'sd13107, 1'b0, 16'sd0,    3'd0},
    '{16'sd13107,  1'b0, 16'sd0,    3'd0},
    '{-16'sd9830,  1'b0, 16'sd0,    3'd0},
    '{16'sd9830,   1'b0, 16'sd0,    3'd0},
    '{-16'sd9830,  1'b0, 16'sd0,    3'd0},
    '{16'sd9830,   1'b0, 16'sd0,    3'd0},
    '{16'sd4915,   1'b0, 16'sd0,    3'd0},
    '{16'sh2aaa,   1'b0, 16'sd0,    3'd0},
    '{-16'sh5555,  1'b0, 16'sd0,    3'd0}
  };

  logic                                 clk;
  logic                                 rst;
  logic                                 sample_valid;
  logic                                 sample_stall;
  logic signed [npep_pkg::SAMPLE_W-1:0] sample;
  logic                                 cfg_write;
  logic [npep_pkg::IDX_W-1:0]           cfg_index;
  logic [npep_pkg::VAL_W-1:0]           cfg_data;
  logic                                 result_valid;
  logic                                 result_stall;
  logic signed [npep_pkg::SAMPLE_W-1:0] drive;
  logic [npep_pkg::IDX_W-1:0]           chosen_model;

  // predictor state
  logic [npep_pkg::VAL_W-1:0] mag_window [WINDOW_TAPS];
  logic [npep_pkg::VAL_W-1:0] model_avg  [MODEL_LANES];
  logic [npep_pkg::VAL_W-1:0] level_reg  [npep_pkg::LEVEL_SLOTS];

  correction_t expected_corrections [$];
  int          error_count;
  bit          calm;
  bit          hold_request;
  int          focus_model;
  int          focus_left;

  nearest_prototype_ema_predictor_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive),
    .chosen_model (chosen_model)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_500_000;
    $display("** nearest_prototype_ema_predictor_top: FAILED **");
    $finish;
  end

  // shift in the new magnitude, pick the nearest level, update its average
  function automatic correction_t project_correction(
    input logic signed [npep_pkg::SAMPLE_W-1:0] s);
    correction_t c;
    int          mag;
    int          diff;
    int          lane_dist;
    int          best_dist;
    int          best;
    int          win_sum;
    int          mean;
    longint      blend;
    logic [npep_pkg::VAL_W-1:0] avg;
    mag = (s < 0) ? -int'(s) : int'(s);
    if (mag > int'(npep_pkg::MAG_MAX)) mag = int'(npep_pkg::MAG_MAX);
    for (int i = WINDOW_TAPS - 1; i > 0; i--) mag_window[i] = mag_window[i-1];
    mag_window[0] = npep_pkg::VAL_W'(mag);
    best = 0;
    best_dist = 0;
    for (int j = 0; j < MODEL_LANES; j++) begin
      lane_dist = 0;
      for (int i = 0; i < WINDOW_TAPS; i++) begin
        diff = int'(mag_window[i]) - int'(level_reg[j]);
        lane_dist += (diff < 0) ? -diff : diff;
      end
      if (j == 0 || lane_dist < best_dist) begin
        best_dist = lane_dist;
        best = j;
      end
    end
    win_sum = 0;
    for (int i = 0; i < WINDOW_TAPS; i++) win_sum += int'(mag_window[i]);
    mean = win_sum / WINDOW_TAPS;
    blend = longint'(npep_pkg::KEEP_WEIGHT) * longint'(model_avg[best])
          + longint'(npep_pkg::NEW_WEIGHT) * longint'(mean);
    avg = npep_pkg::VAL_W'(blend >> 16);
    model_avg[best] = avg;
    if (s == 0) c.drive = '0;
    else if (s < 0) c.drive = $signed({1'b0, avg});
    else c.drive = -$signed({1'b0, avg});
    c.model = npep_pkg::IDX_W'(best);
    return c;
  endfunction

  // random sample, mostly runs near one model's level so the search moves
  function automatic logic signed [npep_pkg::SAMPLE_W-1:0] draw_sample();
    int roll;
    int mag;
    logic signed [npep_pkg::SAMPLE_W-1:0] s;
    if (focus_left == 0) begin
      focus_model = $urandom_range(0, MODEL_LANES - 1);
      focus_left = $urandom_range(8, 40);
    end
    focus_left--;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      mag = int'(level_reg[focus_model]) + int'($urandom_range(0, 800)) - 400;
      if (mag < 0) mag = 0;
      if (mag > int'(npep_pkg::MAG_MAX)) mag = int'(npep_pkg::MAG_MAX);
      s = npep_pkg::SAMPLE_W'(mag);
      if ($urandom_range(0, 1)) s = -s;
    end else if (roll < 80) begin
      s = npep_pkg::SAMPLE_W'($urandom);
    end else if (roll < 90) begin
      case ($urandom_range(0, 3))
        0: s = 16'sh8000;
        1: s = 16'sh7fff;
        2: s = 16'sh8001;
        default: s = '0;
      endcase
    end else begin
      s = npep_pkg::SAMPLE_W'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) s = -s;
    end
    return s;
  endfunction

  // level register write, only while the block is idle
  task automatic write_level(input int idx, input logic [npep_pkg::VAL_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = npep_pkg::IDX_W'(idx);
    cfg_data  = value;
    level_reg[idx] = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // offer one word and hold it until taken, then log what should come back
  task automatic offer_sample(input vector_t row);
    correction_t want;
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = row.smp;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    want = project_correction(row.smp);
    if (row.typed) begin
      want.drive = row.drv;
      want.model = row.mdl;
    end
    expected_corrections.push_back(want);
    @(negedge clk);
  endtask

  // wait until every word has come back and the block has gone quiet
  task automatic drain();
    sample_valid = 1'b0;
    while (expected_corrections.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side back-pressure: random bursts, one long hold on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall = 1'b0;
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        result_stall = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        result_stall = 1'b0;
      end else begin
        result_stall = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_results
    correction_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_corrections.size() == 0) begin
        if (error_count < REPORT_CAP)
          $display("%0t: unexpected word drive=%0d model=%0d", $time, drive, chosen_model);
        error_count++;
      end else begin
        want = expected_corrections.pop_front();
        if (drive !== want.drive) begin
          if (error_count < REPORT_CAP)
            $display("%0t: drive expected %0d actual %0d", $time, want.drive, drive);
          error_count++;
        end
        if (chosen_model !== want.model) begin
          if (error_count < REPORT_CAP)
            $display("%0t: chosen_model expected %0d actual %0d",
                     $time, want.model, chosen_model);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    vector_t row;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_request = 1'b0;
    error_count = 0;
    focus_model = 0;
    focus_left = 0;
    for (int i = 0; i < WINDOW_TAPS; i++) mag_window[i] = '0;
    for (int j = 0; j < MODEL_LANES; j++) model_avg[j] = '0;
    for (int j = 0; j < npep_pkg::LEVEL_SLOTS; j++) level_reg[j] = npep_pkg::LEVEL_RESET[j];
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed words at the reset levels
    for (int r = 0; r < DIRECTED_ROWS; r++) offer_sample(DIRECTED[r]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // level settings: reset values, extremes with ties, all equal, random
      case (p)
        0: ;
        1: begin
          write_level(0, 15'd0);
          write_level(1, 15'd32767);
          write_level(2, 15'd1);
          write_level(3, 15'd32766);
          write_level(4, 15'd16384);
          write_level(5, 15'd32767);
          write_level(6, 15'd0);
          write_level(7, 15'd8191);
        end
        2: for (int j = 0; j < npep_pkg::LEVEL_SLOTS; j++) write_level(j, 15'd8192);
        default:
          for (int j = 0; j < npep_pkg::LEVEL_SLOTS; j++)
            write_level(j, ($urandom_range(0, 7) == 0)
                           ? npep_pkg::MAG_MAX
                           : npep_pkg::VAL_W'($urandom_range(0, 32767)));
      endcase
      if (p == HOLD_PHASE) hold_request = 1'b1;
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        row.smp = draw_sample();
        row.typed = 1'b0;
        row.drv = '0;
        row.mdl = '0;
        offer_sample(row);
      end
    end
    drain();

    if (expected_corrections.size() != 0)
      $display("%0t: %0d words never arrived", $time, expected_corrections.size());
    if (error_count == 0 && expected_corrections.size() == 0) begin
      $display("** nearest_prototype_ema_predictor_top: PASSED **");
    end else begin
      $display("** nearest_prototype_ema_predictor_top: FAILED **");
    end
    $finish;
  end

endmodule
